FILE: hw/rtl/gcars_pkg.sv
// gcars_pkg: types, codes and widths shared by the grid cell arithmetic
// and range statistics unit; no dependencies
package gcars_pkg;

  localparam int GCARS_MAX_ROWS = 64;
  localparam int GCARS_MAX_COLS = 64;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = 44;
  localparam int SQ_W      = 76;
  localparam int DIV_DW    = 76;
  localparam int DIV_VW    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [1:0] MODE_ARITH = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;

  localparam logic [2:0] FN_SUM   = 3'd0;
  localparam logic [2:0] FN_MIN   = 3'd1;
  localparam logic [2:0] FN_MAX   = 3'd2;
  localparam logic [2:0] FN_AVG   = 3'd3;
  localparam logic [2:0] FN_STDEV = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADREF = 2'd1,
    ST_DIVZ   = 2'd2,
    ST_INV    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    AS_TGT, AS_LEFT, AS_RIGHT, AS_SCAN
  } asel_e;

  typedef enum logic [3:0] {
    RS_ZERO, RS_MEM, RS_ARITH, RS_DIVQ, RS_SUM, RS_MIN, RS_MAX, RS_AVG, RS_SQRT
  } rsel_e;

  typedef enum logic [1:0] {
    DS_ARITH, DS_AVG, DS_VAR
  } dsel_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RD_T, S_CAP_T, S_RD_L, S_CAP_L, S_RD_R, S_CAP_R,
    S_EXEC, S_ADIV, S_SCAN_RD, S_SCAN_ACC, S_STAT, S_AVG_WAIT, S_SQ_RD,
    S_SQ_DIFF, S_SQ_MUL, S_SQ_ACC, S_VAR_GO, S_VAR_WAIT, S_SQRT_WAIT, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         func;
    logic [5:0]         target_row;
    logic [5:0]         target_col;
    logic               left_is_cell;
    logic signed [31:0] left_const;
    logic [5:0]         left_row;
    logic [5:0]         left_col;
    logic               right_is_cell;
    logic signed [31:0] right_const;
    logic [5:0]         right_row;
    logic [5:0]         right_col;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               written;
  } out_t;

  typedef struct packed {
    logic    cap;
    logic    clr_wr;
    logic    rd;
    asel_e   asel;
    logic    ld_a;
    logic    ld_b;
    logic    st_ld;
    status_e st;
    logic    res_ld;
    rsel_e   rsel;
    logic    wr_ld;
    logic    wr_val;
    logic    scan_init;
    logic    scan_next;
    logic    acc;
    logic    sq_diff;
    logic    sq_mul;
    logic    sq_acc;
    logic    div_go;
    dsel_e   dsel;
    logic    sqrt_go;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    status_e    chk;
    logic [1:0] mode;
    logic [2:0] func;
    logic       lcell;
    logic       rcell;
    logic       b_zero;
    logic       scan_last;
    logic       div_done;
    logic       sqrt_done;
    logic       out_full;
  } stat_t;

endpackage

FILE: hw/rtl/gcars_div.sv
// gcars_div: restoring unsigned divider, one quotient bit per cycle
// depends on gcars_pkg for widths
module gcars_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gcars_pkg::DIV_DW-1:0]  dividend_i,
  input  logic [gcars_pkg::DIV_VW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [gcars_pkg::DIV_DW-1:0]  quot_o
);
  localparam int DW = gcars_pkg::DIV_DW;
  localparam int VW = gcars_pkg::DIV_VW;
  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem_q, rem_d, dvs_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   sh;
  logic [VW:0]   diff;

  always_comb begin
    sh    = {rem_q, quo_q[DW-1]};
    diff  = sh - {1'b0, dvs_q};
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(DW - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (!diff[VW]) begin
        rem_d = diff[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = sh[VW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

FILE: hw/rtl/gcars_sqrt.sv
// gcars_sqrt: digit-by-digit integer square root with round to nearest
// no package dependencies
module gcars_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] trial;
  logic [63:0] rounded;

  always_comb begin
    trial  = res_q + bit_q;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      n_d    = val_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_d   = n_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  // remainder above the root means the value lies past the midpoint
  assign rounded = res_q + ((n_q > res_q) ? 64'd1 : 64'd0);
  assign done_o  = done_q;
  assign root_o  = rounded[31:0];
endmodule

FILE: hw/rtl/gcars_ctrl.sv
// gcars_ctrl: command sequencer for the grid unit
// depends on gcars_pkg for state, command and status types
module gcars_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gcars_pkg::stat_t  stat_i,
  output gcars_pkg::cmd_t   cmd_o
);
  gcars_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gcars_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.asel = gcars_pkg::AS_TGT;
    cmd_o.st   = gcars_pkg::ST_OK;
    cmd_o.rsel = gcars_pkg::RS_ZERO;
    cmd_o.dsel = gcars_pkg::DS_ARITH;
    unique case (state_q)
      gcars_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) state_d = gcars_pkg::S_IDLE;
      end
      gcars_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = gcars_pkg::S_CHECK;
        end
      end
      gcars_pkg::S_CHECK: begin
        cmd_o.st_ld  = 1'b1;
        cmd_o.st     = stat_i.chk;
        cmd_o.res_ld = 1'b1;
        cmd_o.rsel   = gcars_pkg::RS_ZERO;
        cmd_o.wr_ld  = 1'b1;
        cmd_o.wr_val = 1'b0;
        if (stat_i.chk != gcars_pkg::ST_OK) begin
          state_d = gcars_pkg::S_DONE;
        end else begin
          unique case (stat_i.mode)
            gcars_pkg::MODE_READ: state_d = gcars_pkg::S_RD_T;
            gcars_pkg::MODE_ARITH: begin
              if (stat_i.lcell)      state_d = gcars_pkg::S_RD_L;
              else if (stat_i.rcell) state_d = gcars_pkg::S_RD_R;
              else                   state_d = gcars_pkg::S_EXEC;
            end
            gcars_pkg::MODE_RANGE: begin
              cmd_o.scan_init = 1'b1;
              state_d         = gcars_pkg::S_SCAN_RD;
            end
            default: state_d = gcars_pkg::S_DONE;
          endcase
        end
      end
      gcars_pkg::S_RD_T: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = gcars_pkg::AS_TGT;
        state_d    = gcars_pkg::S_CAP_T;
      end
      gcars_pkg::S_CAP_T: begin
        cmd_o.res_ld = 1'b1;
        cmd_o.rsel   = gcars_pkg::RS_MEM;
        state_d      = gcars_pkg::S_DONE;
      end
      gcars_pkg::S_RD_L: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = gcars_pkg::AS_LEFT;
        state_d    = gcars_pkg::S_CAP_L;
      end
      gcars_pkg::S_CAP_L: begin
        cmd_o.ld_a = 1'b1;
        state_d    = stat_i.rcell ? gcars_pkg::S_RD_R : gcars_pkg::S_EXEC;
      end
      gcars_pkg::S_RD_R: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = gcars_pkg::AS_RIGHT;
        state_d    = gcars_pkg::S_CAP_R;
      end
      gcars_pkg::S_CAP_R: begin
        cmd_o.ld_b = 1'b1;
        state_d    = gcars_pkg::S_EXEC;
      end
      gcars_pkg::S_EXEC: begin
        if (stat_i.func == gcars_pkg::FN_DIV) begin
          if (stat_i.b_zero) begin
            cmd_o.st_ld = 1'b1;
            cmd_o.st    = gcars_pkg::ST_DIVZ;
            state_d     = gcars_pkg::S_DONE;
          end else begin
            cmd_o.div_go = 1'b1;
            cmd_o.dsel   = gcars_pkg::DS_ARITH;
            state_d      = gcars_pkg::S_ADIV;
          end
        end else begin
          cmd_o.res_ld = 1'b1;
          cmd_o.rsel   = gcars_pkg::RS_ARITH;
          cmd_o.wr_ld  = 1'b1;
          cmd_o.wr_val = 1'b1;
          state_d      = gcars_pkg::S_DONE;
        end
      end
      gcars_pkg::S_ADIV: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.rsel   = gcars_pkg::RS_DIVQ;
          cmd_o.wr_ld  = 1'b1;
          cmd_o.wr_val = 1'b1;
          state_d      = gcars_pkg::S_DONE;
        end
      end
      gcars_pkg::S_SCAN_RD: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = gcars_pkg::AS_SCAN;
        state_d    = gcars_pkg::S_SCAN_ACC;
      end
      gcars_pkg::S_SCAN_ACC: begin
        cmd_o.acc = 1'b1;
        if (stat_i.scan_last) begin
          state_d = gcars_pkg::S_STAT;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = gcars_pkg::S_SCAN_RD;
        end
      end
      gcars_pkg::S_STAT: begin
        cmd_o.wr_ld  = 1'b1;
        cmd_o.wr_val = 1'b1;
        case (stat_i.func)
          gcars_pkg::FN_SUM: begin
            cmd_o.res_ld = 1'b1;
            cmd_o.rsel   = gcars_pkg::RS_SUM;
            state_d      = gcars_pkg::S_DONE;
          end
          gcars_pkg::FN_MIN: begin
            cmd_o.res_ld = 1'b1;
            cmd_o.rsel   = gcars_pkg::RS_MIN;
            state_d      = gcars_pkg::S_DONE;
          end
          gcars_pkg::FN_MAX: begin
            cmd_o.res_ld = 1'b1;
            cmd_o.rsel   = gcars_pkg::RS_MAX;
            state_d      = gcars_pkg::S_DONE;
          end
          default: begin
            cmd_o.div_go = 1'b1;
            cmd_o.dsel   = gcars_pkg::DS_AVG;
            state_d      = gcars_pkg::S_AVG_WAIT;
          end
        endcase
      end
      gcars_pkg::S_AVG_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.rsel   = gcars_pkg::RS_AVG;
          if (stat_i.func == gcars_pkg::FN_AVG) begin
            state_d = gcars_pkg::S_DONE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = gcars_pkg::S_SQ_RD;
          end
        end
      end
      gcars_pkg::S_SQ_RD: begin
        cmd_o.rd   = 1'b1;
        cmd_o.asel = gcars_pkg::AS_SCAN;
        state_d    = gcars_pkg::S_SQ_DIFF;
      end
      gcars_pkg::S_SQ_DIFF: begin
        cmd_o.sq_diff = 1'b1;
        state_d       = gcars_pkg::S_SQ_MUL;
      end
      gcars_pkg::S_SQ_MUL: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = gcars_pkg::S_SQ_ACC;
      end
      gcars_pkg::S_SQ_ACC: begin
        cmd_o.sq_acc = 1'b1;
        if (stat_i.scan_last) begin
          state_d = gcars_pkg::S_VAR_GO;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = gcars_pkg::S_SQ_RD;
        end
      end
      gcars_pkg::S_VAR_GO: begin
        cmd_o.div_go = 1'b1;
        cmd_o.dsel   = gcars_pkg::DS_VAR;
        state_d      = gcars_pkg::S_VAR_WAIT;
      end
      gcars_pkg::S_VAR_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.sqrt_go = 1'b1;
          state_d       = gcars_pkg::S_SQRT_WAIT;
        end
      end
      gcars_pkg::S_SQRT_WAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.rsel   = gcars_pkg::RS_SQRT;
          cmd_o.wr_ld  = 1'b1;
          cmd_o.wr_val = 1'b1;
          state_d      = gcars_pkg::S_DONE;
        end
      end
      gcars_pkg::S_DONE: begin
        if (!stat_i.out_full) begin
          cmd_o.out_ld = 1'b1;
          state_d      = gcars_pkg::S_IDLE;
        end
      end
      default: state_d = gcars_pkg::S_IDLE;
    endcase
  end

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gcars_pkg::S_CLEAR) |-> !in_ready_o)
    else $error("input accepted during clearing pass");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !stat_i.out_full)
    else $error("result loaded over a stalled word");

  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_go |=> !stat_i.div_done)
    else $error("divider done right after start");

  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> !cmd_o.out_ld && !cmd_o.rd)
    else $error("clearing pass overlaps a command");
endmodule

FILE: hw/rtl/gcars_dp.sv
// gcars_dp: cell memory, operand and range registers, accumulators,
// divider and square root; depends on gcars_pkg, gcars_div, gcars_sqrt
module gcars_dp #(
  parameter int MAX_ROWS = gcars_pkg::GCARS_MAX_ROWS,
  parameter int MAX_COLS = gcars_pkg::GCARS_MAX_COLS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gcars_pkg::in_t                    in_data_i,
  input  logic                              cfg_we_i,
  input  logic [gcars_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gcars_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output gcars_pkg::out_t                   out_data_o,
  input  gcars_pkg::cmd_t                   cmd_i,
  output gcars_pkg::stat_t                  stat_o
);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = gcars_pkg::SUM_W;
  localparam int SQ_W  = gcars_pkg::SQ_W;
  localparam int CNT_W = gcars_pkg::CNT_W;

  gcars_pkg::in_t          cmd_q;
  logic [6:0]              rows_q, cols_q;
  logic signed [31:0]      a_q, b_q, rdata_q;
  gcars_pkg::status_e      st_q;
  logic [31:0]             res_q, res_d;
  logic                    wr_q;
  logic [5:0]              sr_q, sc_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [31:0]      mn_q, mx_q;
  logic [31:0]             dabs_q;
  logic [63:0]             prod_q;
  logic [SQ_W-1:0]         sumsq_q;
  logic                    out_valid_q;
  gcars_pkg::out_t         out_q;
  logic [AW-1:0]           clr_q;
  logic [31:0]             mem [DEPTH];

  logic [AW-1:0] raddr, waddr;
  logic          mem_we;
  logic [31:0]   wdata;

  function automatic logic ref_ok(logic [5:0] r, logic [5:0] c, logic [6:0] nr,
                                  logic [6:0] nc);
    return ({1'b0, r} < nr) && (32'(r) < MAX_ROWS) &&
           ({1'b0, c} < nc) && (32'(c) < MAX_COLS);
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [5:0] r, logic [5:0] c);
    return AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  // reference and range checks
  logic tgt_ok, l_ok, r_ok;
  gcars_pkg::status_e chk;

  always_comb begin
    tgt_ok = ref_ok(cmd_q.target_row, cmd_q.target_col, rows_q, cols_q);
    l_ok   = ref_ok(cmd_q.left_row, cmd_q.left_col, rows_q, cols_q);
    r_ok   = ref_ok(cmd_q.right_row, cmd_q.right_col, rows_q, cols_q);
    chk    = gcars_pkg::ST_OK;
    unique case (cmd_q.mode)
      gcars_pkg::MODE_READ: begin
        if (!tgt_ok) chk = gcars_pkg::ST_BADREF;
      end
      gcars_pkg::MODE_ARITH: begin
        if (cmd_q.func > gcars_pkg::FN_DIV || !tgt_ok || (cmd_q.left_is_cell && !l_ok) ||
            (cmd_q.right_is_cell && !r_ok)) chk = gcars_pkg::ST_BADREF;
      end
      gcars_pkg::MODE_RANGE: begin
        if (cmd_q.func > gcars_pkg::FN_STDEV || !tgt_ok || !l_ok || !r_ok)
          chk = gcars_pkg::ST_BADREF;
        else if (cmd_q.left_row > cmd_q.right_row || cmd_q.left_col > cmd_q.right_col)
          chk = gcars_pkg::ST_INV;
      end
      default: chk = gcars_pkg::ST_OK;
    endcase
  end

  // memory ports
  always_comb begin
    case (cmd_i.asel)
      gcars_pkg::AS_LEFT:  raddr = cell_addr(cmd_q.left_row, cmd_q.left_col);
      gcars_pkg::AS_RIGHT: raddr = cell_addr(cmd_q.right_row, cmd_q.right_col);
      gcars_pkg::AS_SCAN:  raddr = cell_addr(sr_q, sc_q);
      default:             raddr = cell_addr(cmd_q.target_row, cmd_q.target_col);
    endcase
    mem_we = cmd_i.clr_wr || (cmd_i.out_ld && wr_q);
    waddr  = cmd_i.clr_wr ? clr_q : cell_addr(cmd_q.target_row, cmd_q.target_col);
    wdata  = cmd_i.clr_wr ? 32'd0 : res_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  // divider and square root
  logic [gcars_pkg::DIV_DW-1:0] div_dvd, div_q;
  logic [gcars_pkg::DIV_VW-1:0] div_dvs;
  logic                         div_done, sqrt_done;
  logic [31:0]                  sqrt_root;
  logic [31:0]                  a_abs, b_abs, qlo;
  logic [SUM_W-1:0]             sum_abs;

  always_comb begin
    a_abs   = a_q[31] ? 32'(-a_q) : 32'(a_q);
    b_abs   = b_q[31] ? 32'(-b_q) : 32'(b_q);
    sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    case (cmd_i.dsel)
      gcars_pkg::DS_AVG: begin
        div_dvd = gcars_pkg::DIV_DW'(sum_abs);
        div_dvs = gcars_pkg::DIV_VW'(cnt_q);
      end
      gcars_pkg::DS_VAR: begin
        div_dvd = gcars_pkg::DIV_DW'(sumsq_q);
        div_dvs = gcars_pkg::DIV_VW'(cnt_q);
      end
      default: begin
        div_dvd = gcars_pkg::DIV_DW'(a_abs);
        div_dvs = b_abs;
      end
    endcase
  end

  gcars_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  gcars_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .val_i   (div_q[63:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // result select
  always_comb begin
    qlo   = div_q[31:0];
    res_d = res_q;
    case (cmd_i.rsel)
      gcars_pkg::RS_ZERO: res_d = 32'd0;
      gcars_pkg::RS_MEM:  res_d = rdata_q;
      gcars_pkg::RS_ARITH: begin
        case (cmd_q.func)
          gcars_pkg::FN_ADD: res_d = 32'(a_q + b_q);
          gcars_pkg::FN_SUB: res_d = 32'(a_q - b_q);
          default:           res_d = 32'(a_q * b_q);
        endcase
      end
      gcars_pkg::RS_DIVQ: res_d = (a_q[31] ^ b_q[31]) ? 32'(-qlo) : qlo;
      gcars_pkg::RS_SUM:  res_d = sum_q[31:0];
      gcars_pkg::RS_MIN:  res_d = mn_q;
      gcars_pkg::RS_MAX:  res_d = mx_q;
      gcars_pkg::RS_AVG:  res_d = sum_q[SUM_W-1] ? 32'(-qlo) : qlo;
      gcars_pkg::RS_SQRT: res_d = sqrt_root;
      default:            res_d = res_q;
    endcase
  end

  // square of distance from the mean
  logic signed [32:0] dev;
  assign dev = 33'(rdata_q) - 33'($signed(res_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      cmd_q <= in_data_i;
      a_q   <= in_data_i.left_const;
      b_q   <= in_data_i.right_const;
    end
    if (cmd_i.ld_a) a_q <= rdata_q;
    if (cmd_i.ld_b) b_q <= rdata_q;
    if (cmd_i.st_ld) st_q <= cmd_i.st;
    if (cmd_i.res_ld) res_q <= res_d;
    if (cmd_i.wr_ld) wr_q <= cmd_i.wr_val;
    if (cmd_i.scan_init) begin
      sr_q    <= cmd_q.left_row;
      sc_q    <= cmd_q.left_col;
      cnt_q   <= CNT_W'(7'(cmd_q.right_row) - 7'(cmd_q.left_row) + 7'd1) *
                 CNT_W'(7'(cmd_q.right_col) - 7'(cmd_q.left_col) + 7'd1);
      sum_q   <= '0;
      sumsq_q <= '0;
    end else if (cmd_i.scan_next) begin
      if (sc_q == cmd_q.right_col) begin
        sc_q <= cmd_q.left_col;
        sr_q <= sr_q + 6'd1;
      end else begin
        sc_q <= sc_q + 6'd1;
      end
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + SUM_W'(rdata_q);
      if ((sr_q == cmd_q.left_row && sc_q == cmd_q.left_col) || rdata_q < mn_q)
        mn_q <= rdata_q;
      if ((sr_q == cmd_q.left_row && sc_q == cmd_q.left_col) || rdata_q > mx_q)
        mx_q <= rdata_q;
    end
    if (cmd_i.sq_diff) dabs_q <= dev[32] ? 32'(-dev) : 32'(dev);
    if (cmd_i.sq_mul)  prod_q <= 64'(dabs_q) * 64'(dabs_q);
    if (cmd_i.sq_acc)  sumsq_q <= sumsq_q + SQ_W'(prod_q);
    if (cmd_i.out_ld) begin
      out_q.status  <= st_q;
      out_q.value   <= res_q;
      out_q.written <= wr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= 7'd64;
      cols_q      <= 7'd64;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == gcars_pkg::CFG_ROWS) rows_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == gcars_pkg::CFG_COLS) cols_q <= cfg_data_i;
      if (cmd_i.out_ld)     out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.clr_wr)     clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    stat_o.clr_done  = (32'(clr_q) == DEPTH - 1);
    stat_o.chk       = chk;
    stat_o.mode      = cmd_q.mode;
    stat_o.func      = cmd_q.func;
    stat_o.lcell     = cmd_q.left_is_cell;
    stat_o.rcell     = cmd_q.right_is_cell;
    stat_o.b_zero    = (b_q == 32'sd0);
    stat_o.scan_last = (sr_q == cmd_q.right_row) && (sc_q == cmd_q.right_col);
    stat_o.div_done  = div_done;
    stat_o.sqrt_done = sqrt_done;
    stat_o.out_full  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

FILE: hw/rtl/grid_cell_arith_and_range_stats_unit.sv
// grid_cell_arith_and_range_stats_unit: top level of the grid cell unit
// depends on gcars_pkg, gcars_ctrl and gcars_dp
//
// Commands come in on the in channel (valid/ready), one word per command;
// each command gives exactly one result word on the out channel. The
// config channel writes rows_in_use (index 0) and cols_in_use (index 1)
// and is always ready; write it only while the unit is idle.
// After reset a clearing pass zeroes the cell memory, one cell a cycle,
// all MAX_ROWS*MAX_COLS cells (4096 by default), with in_ready_o low.
// One command at a time. Add, sub, mul and reads finish without the
// divider; div runs the divider unless the divisor is zero; sum/min/max
// scan the range once, avg scans it and then divides by the cell count;
// stdev scans for the mean, scans again for the squared deviations,
// divides them by the cell count, then takes the square root.
// A failed check or undefined mode goes straight to the result word.
// Cells are read through the single memory port one per step, which sets
// the per-cell cost. A finished result waits in the output register while
// the next command is accepted; if the receiver stalls, that command
// holds in its last step until the word is taken.
module grid_cell_arith_and_range_stats_unit #(
  parameter int MAX_ROWS = gcars_pkg::GCARS_MAX_ROWS,
  parameter int MAX_COLS = gcars_pkg::GCARS_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gcars_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gcars_pkg::out_t                 out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gcars_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcars_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  gcars_pkg::cmd_t  cmd;
  gcars_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  gcars_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gcars_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );
endmodule

FILE: tb/sv/tb_grid_cell_arith_and_range_stats_unit.sv
// tb_grid_cell_arith_and_range_stats_unit: self-checking bench for the grid cell unit
// depends on gcars_pkg and grid_cell_arith_and_range_stats_unit
// a cell-grid shadow predicts every result word; random traffic runs under several layouts
`timescale 1ns / 1ps

module tb_grid_cell_arith_and_range_stats_unit;
  import gcars_pkg::*;

  class grid_scoreboard;
    logic signed [31:0] cells [GCARS_MAX_ROWS][GCARS_MAX_COLS];
    int unsigned        rows_lim;
    int unsigned        cols_lim;
    out_t               result_q[$];
    int                 errors;

    function new();
      foreach (cells[r, c]) cells[r][c] = '0;
      rows_lim = 64;
      cols_lim = 64;
      errors   = 0;
    endfunction

    function bit in_grid(int unsigned r, int unsigned c);
      return r < rows_lim && r < GCARS_MAX_ROWS && c < cols_lim && c < GCARS_MAX_COLS;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
      if (idx == CFG_ROWS) rows_lim = d;
      else if (idx == CFG_COLS) cols_lim = d;
    endfunction

    function longint cell_val(int unsigned r, int unsigned c);
      return longint'(cells[r][c]);
    endfunction

    function longint range_stat(logic [2:0] f, int unsigned r0, int unsigned c0,
                                int unsigned r1, int unsigned c1);
      longint       sum, mn, mx, avg, d, ad, cnt;
      logic [127:0] sq, q, rt, tt, ad_w;
      sum = 0;
      mn  = cell_val(r0, c0);
      mx  = mn;
      sq  = '0;
      cnt = longint'((r1 - r0 + 1) * (c1 - c0 + 1));
      for (int unsigned r = r0; r <= r1; r++) begin
        for (int unsigned c = c0; c <= c1; c++) begin
          sum += cell_val(r, c);
          if (cell_val(r, c) < mn) mn = cell_val(r, c);
          if (cell_val(r, c) > mx) mx = cell_val(r, c);
        end
      end
      if (f == FN_SUM) return sum;
      if (f == FN_MIN) return mn;
      if (f == FN_MAX) return mx;
      avg = sum / cnt;
      if (f == FN_AVG) return avg;
      for (int unsigned r = r0; r <= r1; r++) begin
        for (int unsigned c = c0; c <= c1; c++) begin
          d    = cell_val(r, c) - avg;
          ad   = (d < 0) ? -d : d;
          ad_w = 128'(ad);
          sq   = sq + ad_w * ad_w;
        end
      end
      q  = sq / 128'(cnt);
      q  = {64'b0, q[63:0]};
      rt = '0;
      for (int k = 32; k >= 0; k--) begin
        tt = rt | (128'd1 << k);
        if (tt * tt <= q) rt = tt;
      end
      if (q > rt * rt + rt) rt = rt + 1;
      return longint'(rt[63:0]);
    endfunction

    function out_t predict(in_t c);
      out_t    o;
      status_e st;
      longint  a, b, v;
      bit      wr;
      st = ST_OK;
      v  = 0;
      wr = 1'b0;
      case (c.mode)
        MODE_READ: begin
          if (!in_grid(c.target_row, c.target_col)) st = ST_BADREF;
          else v = cell_val(c.target_row, c.target_col);
        end
        MODE_ARITH: begin
          if (c.func > FN_DIV || !in_grid(c.target_row, c.target_col) ||
              (c.left_is_cell && !in_grid(c.left_row, c.left_col)) ||
              (c.right_is_cell && !in_grid(c.right_row, c.right_col))) begin
            st = ST_BADREF;
          end else begin
            a = c.left_is_cell ? cell_val(c.left_row, c.left_col)
                               : longint'($signed(c.left_const));
            b = c.right_is_cell ? cell_val(c.right_row, c.right_col)
                                : longint'($signed(c.right_const));
            case (c.func)
              FN_ADD: v = a + b;
              FN_SUB: v = a - b;
              FN_MUL: v = a * b;
              default: begin
                if (b == 0) st = ST_DIVZ;
                else v = a / b;
              end
            endcase
            wr = (st == ST_OK);
          end
        end
        MODE_RANGE: begin
          if (c.func > FN_STDEV || !in_grid(c.target_row, c.target_col) ||
              !in_grid(c.left_row, c.left_col) || !in_grid(c.right_row, c.right_col)) begin
            st = ST_BADREF;
          end else if (c.left_row > c.right_row || c.left_col > c.right_col) begin
            st = ST_INV;
          end else begin
            v  = range_stat(c.func, c.left_row, c.left_col, c.right_row, c.right_col);
            wr = 1'b1;
          end
        end
        default: ;
      endcase
      o.status  = st;
      o.value   = (st == ST_OK) ? v[31:0] : '0;
      o.written = wr;
      if (wr) cells[c.target_row][c.target_col] = o.value;
      return o;
    endfunction

    function void note_command(in_t c);
      result_q.push_back(predict(c));
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t exp_w;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      exp_w = result_q.pop_front();
      if (got.status !== exp_w.status)
        report($sformatf("status %0d, want %0d", got.status, exp_w.status));
      if (got.value !== exp_w.value)
        report($sformatf("value %0d, want %0d", got.value, exp_w.value));
      if (got.written !== exp_w.written)
        report($sformatf("written %0d, want %0d", got.written, exp_w.written));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  grid_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  bit             hold_req;
  int unsigned    hold_left;
  longint         cycle_cnt;

  grid_cell_arith_and_range_stats_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task send_word(in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(w);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.result_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function in_t cmd(logic [1:0] m, logic [2:0] f, int tr, int tc,
                    bit lic, int lc, int lr, int lcol,
                    bit ric, int rc, int rr, int rcol);
    in_t w;
    w.mode          = m;
    w.func          = f;
    w.target_row    = 6'(tr);
    w.target_col    = 6'(tc);
    w.left_is_cell  = lic;
    w.left_const    = lc;
    w.left_row      = 6'(lr);
    w.left_col      = 6'(lcol);
    w.right_is_cell = ric;
    w.right_const   = rc;
    w.right_row     = 6'(rr);
    w.right_col     = 6'(rcol);
    return w;
  endfunction

  function int unsigned pick_index(int unsigned lim);
    int unsigned p;
    p = $urandom_range(99);
    if (p < 5) return $urandom_range(63);
    if (p < 80) return $urandom_range(((lim < 8) ? lim : 8) - 1);
    return $urandom_range(lim - 1);
  endfunction

  function logic [31:0] pick_const();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'hffff_ffff;
      4: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  function in_t random_cmd();
    in_t         w;
    int unsigned p, t, rl, cl;
    rl = sb.rows_lim;
    cl = sb.cols_lim;
    p  = $urandom_range(99);
    w.mode          = (p < 45) ? MODE_ARITH : (p < 75) ? MODE_RANGE :
                      (p < 95) ? MODE_READ : MODE_NOP;
    w.func          = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) :
                      (w.mode == MODE_RANGE) ? 3'($urandom_range(4)) : 3'($urandom_range(3));
    w.target_row    = 6'(pick_index(rl));
    w.target_col    = 6'(pick_index(cl));
    w.left_is_cell  = 1'($urandom_range(1));
    w.right_is_cell = 1'($urandom_range(1));
    w.left_const    = pick_const();
    w.right_const   = pick_const();
    w.left_row      = 6'(pick_index(rl));
    w.left_col      = 6'(pick_index(cl));
    w.right_row     = 6'(pick_index(rl));
    w.right_col     = 6'(pick_index(cl));
    if (w.mode == MODE_RANGE) begin
      if ($urandom_range(99) < 2) begin
        w.left_row  = '0;
        w.left_col  = '0;
        w.right_row = 6'(rl - 1);
        w.right_col = 6'(cl - 1);
      end else if ($urandom_range(99) < 90) begin
        t = w.left_row + $urandom_range(3);
        w.right_row = 6'((t < rl) ? t : rl - 1);
        t = w.left_col + $urandom_range(3);
        w.right_col = 6'((t < cl) ? t : cl - 1);
        if (w.right_row < w.left_row) w.right_row = w.left_row;
        if (w.right_col < w.left_col) w.right_col = w.left_col;
      end
    end
    return w;
  endfunction

  task run_phase(int rows, int cols, int sidle, int stall, int n, bit hold);
    drain();
    write_reg(CFG_ROWS, CFG_DAT_W'(rows));
    write_reg(CFG_COLS, CFG_DAT_W'(cols));
    send_idle_pct = sidle;
    stall_pct     = stall;
    if (hold) hold_req = 1'b1;
    repeat (n) send_word(random_cmd());
  endtask

  initial begin
    sb            = new();
    cycle_cnt     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b1;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ROWS;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(cmd(MODE_ARITH, FN_ADD, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 1, 0, 0));
    send_word(cmd(MODE_ARITH, FN_SUB, 0, 1, 0, 32'h80000000, 0, 0, 0, 1, 0, 0));
    send_word(cmd(MODE_ARITH, FN_MUL, 0, 2, 0, -7, 0, 0, 0, 123456789, 0, 0));
    send_word(cmd(MODE_ARITH, FN_DIV, 1, 0, 0, 32'h80000000, 0, 0, 0, -1, 0, 0));
    send_word(cmd(MODE_ARITH, FN_DIV, 1, 1, 0, -7, 0, 0, 0, 2, 0, 0));
    send_word(cmd(MODE_ARITH, FN_DIV, 1, 2, 1, 0, 1, 1, 0, 0, 0, 0));
    send_word(cmd(MODE_ARITH, FN_DIV, 1, 2, 0, 5, 0, 0, 1, 0, 5, 5));
    send_word(cmd(MODE_ARITH, FN_SUB, 1, 2, 1, 0, 1, 1, 0, 10, 0, 0));
    send_word(cmd(MODE_ARITH, FN_SUB, 1, 3, 0, 10, 0, 0, 1, 0, 1, 1));
    send_word(cmd(MODE_ARITH, FN_MUL, 3, 0, 1, 0, 1, 2, 1, 0, 0, 2));
    send_word(cmd(MODE_RANGE, FN_SUM, 2, 0, 0, 0, 0, 0, 0, 0, 1, 3));
    send_word(cmd(MODE_RANGE, FN_MIN, 2, 1, 0, 0, 0, 0, 0, 0, 1, 3));
    send_word(cmd(MODE_RANGE, FN_MAX, 2, 2, 0, 0, 0, 0, 0, 0, 1, 3));
    send_word(cmd(MODE_RANGE, FN_AVG, 2, 3, 0, 0, 0, 0, 0, 0, 1, 3));
    send_word(cmd(MODE_RANGE, FN_STDEV, 2, 4, 0, 0, 0, 0, 0, 0, 1, 3));
    send_word(cmd(MODE_RANGE, FN_SUM, 2, 5, 0, 0, 1, 0, 0, 0, 0, 3));
    send_word(cmd(MODE_RANGE, FN_SUM, 2, 5, 0, 0, 0, 3, 0, 0, 1, 0));
    send_word(cmd(MODE_ARITH, 3'd4, 2, 6, 0, 1, 0, 0, 0, 1, 0, 0));
    send_word(cmd(MODE_RANGE, 3'd5, 2, 6, 0, 0, 0, 0, 0, 0, 1, 1));
    send_word(cmd(MODE_NOP, FN_ADD, 2, 6, 0, 1, 0, 0, 0, 1, 0, 0));
    send_word(cmd(MODE_READ, FN_ADD, 2, 4, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(cmd(MODE_RANGE, FN_STDEV, 63, 63, 0, 0, 0, 0, 0, 0, 63, 63));
    send_word(cmd(MODE_READ, FN_ADD, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0));

    run_phase(64, 64, 0, 0, 250, 1'b0);
    run_phase(1, 1, 74, 0, 120, 1'b0);
    run_phase(8, 5, 0, 74, 250, 1'b1);
    run_phase(37, 64, 35, 35, 250, 1'b0);
    run_phase(64, 64, 0, 0, 160, 1'b0);
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
